FILE: design/bdq_pkg.sv
// Shared sizes, codes, types and helpers for the bounded deque.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [STAT_W-1:0] stat_t;

  // Command codes
  localparam cmd_t CMD_PUSH_FRONT = 3'd0;
  localparam cmd_t CMD_PUSH_BACK  = 3'd1;
  localparam cmd_t CMD_POP_FRONT  = 3'd2;
  localparam cmd_t CMD_POP_BACK   = 3'd3;
  localparam cmd_t CMD_DELETE     = 3'd4;

  // Status codes
  localparam stat_t ST_OK      = 2'd0;
  localparam stat_t ST_FULL    = 2'd1;
  localparam stat_t ST_EMPTY   = 2'd2;
  localparam stat_t ST_MISSING = 2'd3;

  // One access to the ring store; offsets are relative to the head slot
  typedef struct packed {
    logic  we;
    idx_t  wr_off;
    idx_t  rd_off;
    data_t wdata;
  } ring_req_t;

  // Fold a sum below twice DEPTH back into the ring
  function automatic idx_t wrap_idx(input logic [IDX_W:0] sum);
    logic [IDX_W:0] folded;
    folded = (sum >= (IDX_W+1)'(DEPTH)) ? sum - (IDX_W+1)'(DEPTH) : sum;
    return folded[IDX_W-1:0];
  endfunction

endpackage

FILE: design/bdq_if.sv
// Valid/ready channels for command words and result words.
// Depends on bdq_pkg for field types.
`timescale 1ns / 1ps

interface bdq_cmd_if;
  logic          valid;
  logic          ready;
  bdq_pkg::cmd_t command;
  bdq_pkg::data_t value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface bdq_res_if;
  logic           valid;
  logic           ready;
  bdq_pkg::stat_t status;
  bdq_pkg::cnt_t  count;
  logic           is_empty;
  bdq_pkg::data_t front_value;
  bdq_pkg::data_t back_value;
  bdq_pkg::data_t removed_value;

  modport source (output valid, output status, output count, output is_empty,
                  output front_value, output back_value, output removed_value,
                  input ready);
  modport sink   (input valid, input status, input count, input is_empty,
                  input front_value, input back_value, input removed_value,
                  output ready);
endinterface

FILE: design/bdq_ring.sv
// Ring store of deque entries: one write port, one registered read port,
// both addressed as offsets from the head slot. Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_ring (
  input  logic               clk_i,
  input  bdq_pkg::idx_t      head_i,
  input  bdq_pkg::ring_req_t req_i,
  output bdq_pkg::data_t     rdata_o
);

  bdq_pkg::data_t mem_q [bdq_pkg::DEPTH];
  bdq_pkg::data_t rdata_q;
  bdq_pkg::idx_t  wr_slot;
  bdq_pkg::idx_t  rd_slot;

  // Map head-relative offsets to physical slots
  assign wr_slot = bdq_pkg::wrap_idx({1'b0, head_i} + {1'b0, req_i.wr_off});
  assign rd_slot = bdq_pkg::wrap_idx({1'b0, head_i} + {1'b0, req_i.rd_off});

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[wr_slot] <= req_i.wdata;
    end
    rdata_q <= mem_q[rd_slot];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/bounded_deque_with_value_delete.sv
// Bounded deque with removal of the first entry matching a value.
// Depends on bdq_pkg, bdq_cmd_if / bdq_res_if and bdq_ring.
//
//   channel  dir  handshake     word contents
//   in_i     in   valid/ready   command, value
//   out_o    out  valid/ready   status, count, is_empty, front/back/removed value
//
// Inserts and refused commands pass through accept, execute and hand-off.
// Front and back removals add a fetch step (one ring read to refetch the new end) unless the deque empties.
// Remove by value walks every live entry, hit or miss: the scan reads up to
// the match and compaction moves the rest, one entry per cycle on the single
// ring read port.
// Reset clears the count and head; the ring itself needs no clearing.
// A held result does not block the next command; only a second finished
// result waits in the done state until the output register frees up.
`timescale 1ns / 1ps

module bounded_deque_with_value_delete (
  input  logic   clk_i,
  input  logic   rst_ni,
  bdq_cmd_if.sink   in_i,
  bdq_res_if.source out_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]      state_q, state_d;
  bdq_pkg::cmd_t   cmd_q, cmd_d;
  bdq_pkg::data_t  val_q, val_d;
  bdq_pkg::idx_t   head_q, head_d;
  bdq_pkg::cnt_t   count_q, count_d;
  bdq_pkg::data_t  front_q, front_d;
  bdq_pkg::data_t  back_q, back_d;
  bdq_pkg::data_t  removed_q, removed_d;
  bdq_pkg::stat_t  status_q, status_d;
  bdq_pkg::idx_t   pos_q, pos_d;
  bdq_pkg::data_t  prev_q, prev_d;
  logic            fetch_front_q, fetch_front_d;

  logic            out_valid_q, out_valid_d;
  bdq_pkg::stat_t  out_status_q, out_status_d;
  bdq_pkg::cnt_t   out_count_q, out_count_d;
  logic            out_empty_q, out_empty_d;
  bdq_pkg::data_t  out_front_q, out_front_d;
  bdq_pkg::data_t  out_back_q, out_back_d;
  bdq_pkg::data_t  out_removed_q, out_removed_d;

  bdq_pkg::ring_req_t ring_req;
  bdq_pkg::data_t     rdata;
  bdq_pkg::cnt_t      cnt_m1;
  bdq_pkg::cnt_t      cnt_m2;
  bdq_pkg::idx_t      last_pos;
  logic               is_full;
  logic               is_empty;

  bdq_ring u_ring (
    .clk_i   (clk_i),
    .head_i  (head_q),
    .req_i   (ring_req),
    .rdata_o (rdata)
  );

  assign cnt_m1   = count_q - bdq_pkg::CNT_W'(1);
  assign cnt_m2   = count_q - bdq_pkg::CNT_W'(2);
  assign last_pos = cnt_m1[bdq_pkg::IDX_W-1:0];
  assign is_full  = (count_q == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
  assign is_empty = (count_q == '0);

  assign in_i.ready = (state_q == S_IDLE);

  // Sequencer: decode, ring accesses, scan and compaction
  always_comb begin
    state_d        = state_q;
    cmd_d          = cmd_q;
    val_d          = val_q;
    head_d         = head_q;
    count_d        = count_q;
    front_d        = front_q;
    back_d         = back_q;
    removed_d      = removed_q;
    status_d       = status_q;
    pos_d          = pos_q;
    prev_d         = prev_q;
    fetch_front_d  = fetch_front_q;
    ring_req.we     = 1'b0;
    ring_req.wr_off = '0;
    ring_req.rd_off = '0;
    ring_req.wdata  = val_q;

    out_valid_d   = out_valid_q & ~out_o.ready;
    out_status_d  = out_status_q;
    out_count_d   = out_count_q;
    out_empty_d   = out_empty_q;
    out_front_d   = out_front_q;
    out_back_d    = out_back_q;
    out_removed_d = out_removed_q;

    case (state_q)
      S_IDLE: begin
        // Latch the command word
        if (in_i.valid) begin
          cmd_d   = in_i.command;
          val_d   = in_i.value;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        status_d  = bdq_pkg::ST_OK;
        removed_d = '0;
        state_d   = S_DONE;
        case (cmd_q)
          bdq_pkg::CMD_PUSH_FRONT: begin
            if (is_full) begin
              status_d = bdq_pkg::ST_FULL;
            end else begin
              ring_req.we     = 1'b1;
              ring_req.wr_off = bdq_pkg::IDX_W'(bdq_pkg::DEPTH - 1);
              head_d  = bdq_pkg::wrap_idx({1'b0, head_q} +
                                          (bdq_pkg::IDX_W+1)'(bdq_pkg::DEPTH - 1));
              count_d = count_q + bdq_pkg::CNT_W'(1);
              front_d = val_q;
              if (is_empty) begin
                back_d = val_q;
              end
            end
          end
          bdq_pkg::CMD_PUSH_BACK: begin
            if (is_full) begin
              status_d = bdq_pkg::ST_FULL;
            end else begin
              ring_req.we     = 1'b1;
              ring_req.wr_off = count_q[bdq_pkg::IDX_W-1:0];
              count_d = count_q + bdq_pkg::CNT_W'(1);
              back_d  = val_q;
              if (is_empty) begin
                front_d = val_q;
              end
            end
          end
          bdq_pkg::CMD_POP_FRONT: begin
            if (is_empty) begin
              status_d = bdq_pkg::ST_EMPTY;
            end else begin
              removed_d = front_q;
              head_d    = bdq_pkg::wrap_idx({1'b0, head_q} + (bdq_pkg::IDX_W+1)'(1));
              count_d   = cnt_m1;
              // Refetch the new front
              if (cnt_m1 != '0) begin
                ring_req.rd_off = bdq_pkg::IDX_W'(1);
                fetch_front_d   = 1'b1;
                state_d         = S_FETCH;
              end
            end
          end
          bdq_pkg::CMD_POP_BACK: begin
            if (is_empty) begin
              status_d = bdq_pkg::ST_EMPTY;
            end else begin
              removed_d = back_q;
              count_d   = cnt_m1;
              // Refetch the new back
              if (cnt_m1 != '0) begin
                ring_req.rd_off = cnt_m2[bdq_pkg::IDX_W-1:0];
                fetch_front_d   = 1'b0;
                state_d         = S_FETCH;
              end
            end
          end
          bdq_pkg::CMD_DELETE: begin
            if (is_empty) begin
              status_d = bdq_pkg::ST_EMPTY;
            end else begin
              ring_req.rd_off = '0;
              pos_d           = '0;
              state_d         = S_SCAN;
            end
          end
          default: ;
        endcase
      end

      S_FETCH: begin
        if (fetch_front_q) begin
          front_d = rdata;
        end else begin
          back_d = rdata;
        end
        state_d = S_DONE;
      end

      S_SCAN: begin
        // Compare the entry at pos_q, prefetch the next one
        prev_d          = rdata;
        ring_req.rd_off = bdq_pkg::wrap_idx({1'b0, pos_q} + (bdq_pkg::IDX_W+1)'(1));
        if (rdata == val_q) begin
          removed_d = rdata;
          if (pos_q == last_pos) begin
            // Match at the back: the entry before it becomes the back
            if (pos_q != '0) begin
              back_d = prev_q;
            end
            count_d = cnt_m1;
            state_d = S_DONE;
          end else begin
            state_d = S_SHIFT;
          end
        end else if (pos_q == last_pos) begin
          status_d = bdq_pkg::ST_MISSING;
          state_d  = S_DONE;
        end else begin
          pos_d = pos_q + bdq_pkg::IDX_W'(1);
        end
      end

      S_SHIFT: begin
        // Move the entry after pos_q one place toward the front
        ring_req.we     = 1'b1;
        ring_req.wr_off = pos_q;
        ring_req.wdata  = rdata;
        ring_req.rd_off = bdq_pkg::wrap_idx({1'b0, pos_q} + (bdq_pkg::IDX_W+1)'(2));
        if (pos_q == '0) begin
          front_d = rdata;
        end
        if (pos_q + bdq_pkg::IDX_W'(1) == last_pos) begin
          count_d = cnt_m1;
          state_d = S_DONE;
        end else begin
          pos_d = pos_q + bdq_pkg::IDX_W'(1);
        end
      end

      S_DONE: begin
        // Hand the result to the output register once it is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d   = 1'b1;
          out_status_d  = status_q;
          out_count_d   = count_q;
          out_empty_d   = is_empty;
          out_front_d   = is_empty ? '0 : front_q;
          out_back_d    = is_empty ? '0 : back_q;
          out_removed_d = removed_q;
          state_d       = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    val_q         <= val_d;
    front_q       <= front_d;
    back_q        <= back_d;
    removed_q     <= removed_d;
    status_q      <= status_d;
    pos_q         <= pos_d;
    prev_q        <= prev_d;
    fetch_front_q <= fetch_front_d;
    out_status_q  <= out_status_d;
    out_count_q   <= out_count_d;
    out_empty_q   <= out_empty_d;
    out_front_q   <= out_front_d;
    out_back_q    <= out_back_d;
    out_removed_q <= out_removed_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.count         = out_count_q;
  assign out_o.is_empty      = out_empty_q;
  assign out_o.front_value   = out_front_q;
  assign out_o.back_value    = out_back_q;
  assign out_o.removed_value = out_removed_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
    else $error("entry count above depth");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_SHIFT) |-> ({1'b0, pos_q} < count_q))
    else $error("scan position outside live entries");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == bdq_pkg::ST_FULL)
      |-> (out_count_q == bdq_pkg::CNT_W'(bdq_pkg::DEPTH)))
    else $error("full status with room left");

  a_idle_holds_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> (count_q == $past(count_q)))
    else $error("count changed while idle");

endmodule
